>>> rtl/core/mask_layered_rgb_blend_macros.svh
// Assertion macros shared by the mask-layered RGB blend RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MASK_LAYERED_RGB_BLEND_MACROS_SVH
`define MASK_LAYERED_RGB_BLEND_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mask_layered_rgb_blend: same-cycle check failed");

// Consequent must hold after the antecedent, delayed by the n argument.
`define MLRB_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("mask_layered_rgb_blend: delayed check failed");

`endif

>>> rtl/core/mlrb_pkg.sv
// Shared types and constants for the mask-layered RGB blend.
// Depends on nothing; imported by every module of the block.
package mlrb_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int RGB_W       = CHAN_W * NUM_CHAN;
   localparam int PIXEL_W     = 32;
   localparam int MASK_W      = 24;
   localparam int NUM_LAYERS  = 3;
   localparam int CELL_STAGES = 2;
   localparam int LATENCY     = NUM_LAYERS * CELL_STAGES;

   localparam logic [CHAN_W-1:0] BLEND_FULL = 8'd255;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [RGB_W-1:0]  rgb_type;

endpackage

>>> rtl/core/mlrb_lane.sv
// One colour channel of a blend cell: multiply stage then divide-by-255 stage.
// Depends on mlrb_pkg.
module mlrb_lane
   import mlrb_pkg::*;
(
   input  logic     clock,
   input  chan_type cur,
   input  chan_type layer,
   input  chan_type amt,
   output chan_type blended
);

   logic signed [CHAN_W:0] diff;
   logic                   neg;
   chan_type               mag;
   logic [2*CHAN_W-1:0]    prod_in;
   logic [2*CHAN_W-1:0]    prod_ff;
   logic                   neg_ff;
   chan_type               cur_ff;
   logic [2*CHAN_W:0]      quot_sum;
   chan_type               quot;
   chan_type               blended_in;
   chan_type               blended_ff;

   // First stage: magnitude of the difference times the blend amount.
   always_comb begin
      diff    = $signed({1'b0, layer}) - $signed({1'b0, cur});
      neg     = diff[CHAN_W];
      mag     = neg ? chan_type'(-diff) : chan_type'(diff);
      prod_in = {{CHAN_W{1'b0}}, mag} * {{CHAN_W{1'b0}}, amt};
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg;
      cur_ff  <= cur;
   end

   // Second stage: x / 255 as (x + (x >> 8) + 1) >> 8, exact for every product
   // that can occur; the sign is applied afterwards so the quotient truncates
   // toward zero.
   always_comb begin
      quot_sum   = {1'b0, prod_ff} + {{(CHAN_W+1){1'b0}}, prod_ff[2*CHAN_W-1:CHAN_W]}
                   + {{(2*CHAN_W){1'b0}}, 1'b1};
      quot       = quot_sum[2*CHAN_W-1:CHAN_W];
      blended_in = neg_ff ? (cur_ff - quot) : (cur_ff + quot);
   end

   always_ff @(posedge clock) begin
      blended_ff <= blended_in;
   end

   assign blended = blended_ff;

endmodule

>>> rtl/core/mlrb_cell.sv
// One blend cell of the chain: three channel lanes plus a two-stage side band.
// Depends on mlrb_pkg and mlrb_lane.
module mlrb_cell
   import mlrb_pkg::*;
#(
   parameter int SIDE_W = CHAN_W
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  rgb_type           cur_in,
   input  rgb_type           layer_in,
   input  chan_type          amt_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output rgb_type           rgb_out,
   output logic [SIDE_W-1:0] side_out
);

   logic              valid_s1_ff;
   logic              valid_ff;
   logic [SIDE_W-1:0] side_s1_ff;
   logic [SIDE_W-1:0] side_ff;

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
      mlrb_lane u_lane (
         .clock   (clock),
         .cur     (cur_in[c*CHAN_W +: CHAN_W]),
         .layer   (layer_in[c*CHAN_W +: CHAN_W]),
         .amt     (amt_in),
         .blended (rgb_out[c*CHAN_W +: CHAN_W])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         valid_s1_ff <= valid_in;
         valid_ff    <= valid_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      side_s1_ff <= side_in;
      side_ff    <= side_s1_ff;
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;

endmodule

>>> rtl/core/mask_layered_rgb_blend.sv
// Mask-layered RGB blend: a chain of three blend cells, two stages each.
// An accepted request passes through every cell stage to its result strobe.
// Throughput is one request per clock; busy is never raised.
// Synchronous active-high reset clears only the valid flags in each cell.
// Depends on mlrb_pkg, mlrb_cell and the assertion macro header.
`include "mask_layered_rgb_blend_macros.svh"

module mask_layered_rgb_blend
   import mlrb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PIXEL_W-1:0] req_base_pixel,
   input  logic [PIXEL_W-1:0] req_red_layer_pixel,
   input  logic [PIXEL_W-1:0] req_green_layer_pixel,
   input  logic [PIXEL_W-1:0] req_blue_layer_pixel,
   input  logic [MASK_W-1:0]  req_mask_pixel,
   output logic               rsp_strobe,
   output logic [PIXEL_W-1:0] rsp_mixed_pixel
);

   // Side band widths: the first cell carries alpha plus the green and blue
   // layers and amounts, the second alpha plus the blue layer and amount, and
   // the third alpha alone.
   localparam int SIDE0_W = CHAN_W + 2 * (RGB_W + CHAN_W);
   localparam int SIDE1_W = CHAN_W + RGB_W + CHAN_W;
   localparam int SIDE2_W = CHAN_W;

   logic               req_accept;
   chan_type           mask_r;
   chan_type           mask_g;
   chan_type           mask_b;
   chan_type           alpha_sel;
   logic [SIDE0_W-1:0] side0_in;
   logic [SIDE0_W-1:0] side0_out;
   logic [SIDE1_W-1:0] side1_in;
   logic [SIDE1_W-1:0] side1_out;
   logic [SIDE2_W-1:0] side2_out;
   logic               valid0;
   logic               valid1;
   logic               valid2;
   rgb_type            rgb0;
   rgb_type            rgb1;
   rgb_type            rgb2;

   // The pipeline never stalls, so every start is taken as a request.
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   assign mask_r = req_mask_pixel[2*CHAN_W +: CHAN_W];
   assign mask_g = req_mask_pixel[CHAN_W +: CHAN_W];
   assign mask_b = req_mask_pixel[0 +: CHAN_W];

   // Alpha is never blended. It is taken from the last layer whose mask
   // amount is full, and from the base pixel when none of them is; the later
   // layer wins because it would have overwritten the colour anyway.
   always_comb begin
      priority if (mask_b == BLEND_FULL) begin
         alpha_sel = req_blue_layer_pixel[RGB_W +: CHAN_W];
      end else if (mask_g == BLEND_FULL) begin
         alpha_sel = req_green_layer_pixel[RGB_W +: CHAN_W];
      end else if (mask_r == BLEND_FULL) begin
         alpha_sel = req_red_layer_pixel[RGB_W +: CHAN_W];
      end else begin
         alpha_sel = req_base_pixel[RGB_W +: CHAN_W];
      end
   end

   // The later layers ride alongside the colour so that each cell finds its
   // own layer and amount in the cycle its blend starts.
   assign side0_in = {alpha_sel,
                      req_green_layer_pixel[RGB_W-1:0], mask_g,
                      req_blue_layer_pixel[RGB_W-1:0],  mask_b};

   // First cell: base toward the red layer by the mask red amount.
   mlrb_cell #(
      .SIDE_W (SIDE0_W)
   ) u_cell_red (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (req_accept),
      .cur_in    (req_base_pixel[RGB_W-1:0]),
      .layer_in  (req_red_layer_pixel[RGB_W-1:0]),
      .amt_in    (mask_r),
      .side_in   (side0_in),
      .valid_out (valid0),
      .rgb_out   (rgb0),
      .side_out  (side0_out)
   );

   assign side1_in = {side0_out[SIDE0_W-1 -: CHAN_W], side0_out[RGB_W+CHAN_W-1:0]};

   // Second cell: toward the green layer by the mask green amount.
   mlrb_cell #(
      .SIDE_W (SIDE1_W)
   ) u_cell_green (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (valid0),
      .cur_in    (rgb0),
      .layer_in  (side0_out[2*CHAN_W+2*RGB_W-1 -: RGB_W]),
      .amt_in    (side0_out[RGB_W+2*CHAN_W-1 -: CHAN_W]),
      .side_in   (side1_in),
      .valid_out (valid1),
      .rgb_out   (rgb1),
      .side_out  (side1_out)
   );

   // Third cell: toward the blue layer by the mask blue amount.
   mlrb_cell #(
      .SIDE_W (SIDE2_W)
   ) u_cell_blue (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (valid1),
      .cur_in    (rgb1),
      .layer_in  (side1_out[RGB_W+CHAN_W-1 -: RGB_W]),
      .amt_in    (side1_out[CHAN_W-1:0]),
      .side_in   (side1_out[SIDE1_W-1 -: CHAN_W]),
      .valid_out (valid2),
      .rgb_out   (rgb2),
      .side_out  (side2_out)
   );

   // The last cell's outputs are registers, so the result is glitch free.
   assign rsp_strobe      = valid2;
   assign rsp_mixed_pixel = {side2_out, rgb2};

   // Every request yields a strobe once it has passed all three cells, and no strobe
   // appears without a request behind it.
   `MLRB_ASSERT_DELAY(a_req_gives_rsp, clock, reset, req_accept, LATENCY, rsp_strobe)
   `MLRB_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_strobe, $past(req_accept, LATENCY))
   // A full blue amount must reproduce the blue layer pixel exactly.
   `MLRB_ASSERT_DELAY(a_full_blue, clock, reset, req_accept && (mask_b == BLEND_FULL), LATENCY, rsp_mixed_pixel == $past(req_blue_layer_pixel, LATENCY))
   // An all-zero mask must pass the base pixel through untouched.
   `MLRB_ASSERT_DELAY(a_zero_mask, clock, reset, req_accept && (req_mask_pixel == '0), LATENCY, rsp_mixed_pixel == $past(req_base_pixel, LATENCY))

endmodule
